[hw/rtl/gdfs_pkg.sv]
// Shared codes, field widths and control bundles for the grid path finder.
// No dependencies; every other file of the block imports it.
package gdfs_pkg;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 6;
  localparam int KIND_W     = 2;
  localparam int STEP_W     = 12;
  localparam int LEN_W      = 13;
  localparam int SIDE_W     = 7;
  localparam int SIDEX_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIR_W      = 3;

  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEST    = 2'd2;

  // Neighbour order: row+1, col-1, row-1, col+1, then exhausted
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd2;

  typedef struct packed {
    logic grid_we;
    logic vis_we;
    logic vis_wdata;
  } cell_ctl_t;

  typedef struct packed {
    logic we;
    logic re;
  } stk_ctl_t;

endpackage

[hw/rtl/grid_dfs_path_finder.sv]
// Top level of the grid path finder: configuration registers and memory wiring.
// Depends on gdfs_pkg, gdfs_cell_store, gdfs_path_stack and gdfs_ctrl.
//
// One command beat in, one result beat out. A cell write and a path read are
// each a single access to its memory. A search first sweeps the visited map,
// one entry a cycle over 2**(2*clog2(MAX_SIDE)) entries, then reads the cell of
// each neighbour in bounds and then decides on it, skips each neighbour out of
// bounds, and backs out of a cell by reading the frame below it from the stack,
// or from registers when it returns to the start cell. The next command is
// taken while a result still waits in the output register. Configuration writes
// are always ready and must only be issued while no command is in flight. A start
// cell outside the grid gives a rejected result with no path; cells never written
// read as whatever the memory holds.
module grid_dfs_path_finder #(
  parameter int MAX_SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gdfs_pkg::FUNC_W-1:0]        in_func,
  input  logic [gdfs_pkg::COORD_W-1:0]       in_cell_row,
  input  logic [gdfs_pkg::COORD_W-1:0]       in_cell_col,
  input  logic [gdfs_pkg::KIND_W-1:0]        in_cell_kind,
  input  logic [gdfs_pkg::STEP_W-1:0]        in_step_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic                               out_path_found,
  output logic [gdfs_pkg::LEN_W-1:0]         out_path_length,
  output logic [gdfs_pkg::COORD_W-1:0]       out_step_row,
  output logic [gdfs_pkg::COORD_W-1:0]       out_step_col,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gdfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gdfs_pkg::*;

  localparam int LW  = $clog2(MAX_SIDE);
  localparam int AW  = 2 * LW;
  localparam int SAW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int EW  = 2 * LW + DIR_W;

  logic [SIDE_W-1:0]  grid_side_r;
  logic [COORD_W-1:0] start_row_r, start_col_r;

  cell_ctl_t         cell_ctl;
  logic [AW-1:0]     cell_addr;
  logic [KIND_W-1:0] cell_wdata, grid_rdata;
  logic              vis_rdata;
  stk_ctl_t          stk_ctl;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [EW-1:0]     stk_wdata, stk_rdata;

  // Register writes land in the cycle after cfg_valid; never hold the port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_W'(16);
      start_row_r <= '0;
      start_col_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_SIDE: grid_side_r <= cfg_data;
        CFG_START_ROW: start_row_r <= cfg_data[COORD_W-1:0];
        CFG_START_COL: start_col_r <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  gdfs_cell_store #(.AW(AW)) u_cell (
    .clk        (clk),
    .ctl        (cell_ctl),
    .addr       (cell_addr),
    .grid_wdata (cell_wdata),
    .grid_rdata (grid_rdata),
    .vis_rdata  (vis_rdata)
  );

  gdfs_path_stack #(.SAW(SAW), .EW(EW)) u_stack (
    .clk   (clk),
    .ctl   (stk_ctl),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  gdfs_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .in_cell_kind    (in_cell_kind),
    .in_step_index   (in_step_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_accepted    (out_accepted),
    .out_path_found  (out_path_found),
    .out_path_length (out_path_length),
    .out_step_row    (out_step_row),
    .out_step_col    (out_step_col),
    .grid_side       (grid_side_r),
    .start_row       (start_row_r),
    .start_col       (start_col_r),
    .cell_ctl        (cell_ctl),
    .cell_addr       (cell_addr),
    .cell_wdata      (cell_wdata),
    .grid_rdata      (grid_rdata),
    .vis_rdata       (vis_rdata),
    .stk_ctl         (stk_ctl),
    .stk_waddr       (stk_waddr),
    .stk_wdata       (stk_wdata),
    .stk_raddr       (stk_raddr),
    .stk_rdata       (stk_rdata)
  );

endmodule

[hw/rtl/gdfs_cell_store.sv]
// Grid kind memory and visited map, sharing one address per cycle.
// Depends on gdfs_pkg for the control bundle.
module gdfs_cell_store #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  gdfs_pkg::cell_ctl_t       ctl,
  input  logic [AW-1:0]             addr,
  input  logic [gdfs_pkg::KIND_W-1:0] grid_wdata,
  output logic [gdfs_pkg::KIND_W-1:0] grid_rdata,
  output logic                      vis_rdata
);
  import gdfs_pkg::*;

  logic [KIND_W-1:0] grid_mem [2**AW];
  logic              vis_mem  [2**AW];
  logic [KIND_W-1:0] grid_rdata_r;
  logic              vis_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.grid_we) begin
      grid_mem[addr] <= grid_wdata;
    end
    grid_rdata_r <= grid_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.vis_we) begin
      vis_mem[addr] <= ctl.vis_wdata;
    end
    vis_rdata_r <= vis_mem[addr];
  end

  assign grid_rdata = grid_rdata_r;
  assign vis_rdata  = vis_rdata_r;

endmodule

[hw/rtl/gdfs_path_stack.sv]
// Search stack memory: one row, column and next-direction entry per depth.
// Depends on gdfs_pkg for the control bundle.
module gdfs_path_stack #(
  parameter int SAW = 12,
  parameter int EW  = 15
) (
  input  logic                 clk,
  input  gdfs_pkg::stk_ctl_t   ctl,
  input  logic [SAW-1:0]       waddr,
  input  logic [EW-1:0]        wdata,
  input  logic [SAW-1:0]       raddr,
  output logic [EW-1:0]        rdata
);
  import gdfs_pkg::*;

  logic [EW-1:0] stk_mem [2**SAW];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      stk_mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= stk_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/gdfs_ctrl.sv]
// Command sequencer and depth-first search engine with the result register.
// Depends on gdfs_pkg; drives gdfs_cell_store and gdfs_path_stack.
module gdfs_ctrl #(
  parameter int MAX_SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gdfs_pkg::FUNC_W-1:0]        in_func,
  input  logic [gdfs_pkg::COORD_W-1:0]       in_cell_row,
  input  logic [gdfs_pkg::COORD_W-1:0]       in_cell_col,
  input  logic [gdfs_pkg::KIND_W-1:0]        in_cell_kind,
  input  logic [gdfs_pkg::STEP_W-1:0]        in_step_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic                               out_path_found,
  output logic [gdfs_pkg::LEN_W-1:0]         out_path_length,
  output logic [gdfs_pkg::COORD_W-1:0]       out_step_row,
  output logic [gdfs_pkg::COORD_W-1:0]       out_step_col,
  input  logic [gdfs_pkg::SIDE_W-1:0]        grid_side,
  input  logic [gdfs_pkg::COORD_W-1:0]       start_row,
  input  logic [gdfs_pkg::COORD_W-1:0]       start_col,
  output gdfs_pkg::cell_ctl_t                cell_ctl,
  output logic [2*$clog2(MAX_SIDE)-1:0]      cell_addr,
  output logic [gdfs_pkg::KIND_W-1:0]        cell_wdata,
  input  logic [gdfs_pkg::KIND_W-1:0]        grid_rdata,
  input  logic                               vis_rdata,
  output gdfs_pkg::stk_ctl_t                 stk_ctl,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] stk_waddr,
  output logic [2*$clog2(MAX_SIDE)+gdfs_pkg::DIR_W-1:0] stk_wdata,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] stk_raddr,
  input  logic [2*$clog2(MAX_SIDE)+gdfs_pkg::DIR_W-1:0] stk_rdata
);
  import gdfs_pkg::*;

  localparam int LW     = $clog2(MAX_SIDE);
  localparam int AW     = 2 * LW;
  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int SAW    = $clog2(CELLS);
  localparam int DW     = $clog2(CELLS + 1);
  localparam int EW_TOP = 2 * LW + DIR_W - 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_PROBE = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_POPW  = 4'd7;
  localparam logic [3:0] S_FWR   = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]          st_r, st_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [LW-1:0]       cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [DIR_W-1:0]    cur_dir_r, cur_dir_nxt, sdir_r, sdir_nxt;
  logic [LW-1:0]       nbr_row_r, nbr_row_nxt, nbr_col_r, nbr_col_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic                found_r, found_nxt;
  logic                acc_r, acc_nxt;
  logic [COORD_W-1:0]  srow_r, srow_nxt, scol_r, scol_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt, out_found_r, out_found_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [COORD_W-1:0]  out_row_r, out_row_nxt, out_col_r, out_col_nxt;

  logic [SIDEX_W-1:0]  side_eff;
  logic                nb_ok;
  logic [LW-1:0]       nb_row, nb_col;
  logic [LW-1:0]       st_row, st_col;
  logic                start_ok;

  assign side_eff = ({1'b0, grid_side} > SIDEX_W'(MAX_SIDE)) ? SIDEX_W'(MAX_SIDE)
                                                              : {1'b0, grid_side};
  assign start_ok = (SIDEX_W'(start_row) < side_eff) && (SIDEX_W'(start_col) < side_eff);
  assign st_row   = LW'(start_row);
  assign st_col   = LW'(start_col);

  // Neighbour of the current frame in its next direction, with bounds check
  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (cur_dir_r)
      DIR_DOWN: begin
        nb_row = cur_row_r + LW'(1);
        nb_ok  = (SIDEX_W'(cur_row_r) + SIDEX_W'(1)) < side_eff;
      end
      DIR_LEFT: begin
        nb_col = cur_col_r - LW'(1);
        nb_ok  = (cur_col_r != '0);
      end
      DIR_UP: begin
        nb_row = cur_row_r - LW'(1);
        nb_ok  = (cur_row_r != '0);
      end
      DIR_RIGHT: begin
        nb_col = cur_col_r + LW'(1);
        nb_ok  = (SIDEX_W'(cur_col_r) + SIDEX_W'(1)) < side_eff;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    func_nxt      = func_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    kind_nxt      = kind_r;
    step_nxt      = step_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cur_dir_nxt   = cur_dir_r;
    sdir_nxt      = sdir_r;
    nbr_row_nxt   = nbr_row_r;
    nbr_col_nxt   = nbr_col_r;
    depth_nxt     = depth_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_acc_nxt   = out_acc_r;
    out_found_nxt = out_found_r;
    out_len_nxt   = out_len_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;

    cell_ctl   = '0;
    cell_addr  = {nbr_row_r, nbr_col_r};
    cell_wdata = kind_r;
    stk_ctl    = '0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          row_nxt  = in_cell_row;
          col_nxt  = in_cell_col;
          kind_nxt = in_cell_kind;
          step_nxt = in_step_index;
          st_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        acc_nxt  = 1'b0;
        srow_nxt = '0;
        scol_nxt = '0;
        st_nxt   = S_DONE;
        unique case (func_r)
          FUNC_WRITE: begin
            cell_addr = {LW'(row_r), LW'(col_r)};
            if ((SIDEX_W'(row_r) < side_eff) && (SIDEX_W'(col_r) < side_eff) &&
                (kind_r <= KIND_DEST)) begin
              cell_ctl.grid_we = 1'b1;
              acc_nxt          = 1'b1;
            end
          end
          FUNC_SEARCH: begin
            found_nxt = 1'b0;
            depth_nxt = '0;
            if (start_ok) begin
              clr_cnt_nxt = '0;
              st_nxt      = S_CLR;
            end
          end
          FUNC_READ: begin
            stk_raddr = SAW'(step_r);
            if (found_r && (32'(step_r) < 32'(depth_r))) begin
              stk_ctl.re = 1'b1;
              st_nxt     = S_RDW;
            end
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_CLR: begin
        cell_addr          = clr_cnt_r;
        cell_ctl.vis_we    = 1'b1;
        cell_ctl.vis_wdata = 1'b0;
        clr_cnt_nxt        = clr_cnt_r + AW'(1);
        if (clr_cnt_r == '1) begin
          st_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cell_addr          = {st_row, st_col};
        cell_ctl.vis_we    = 1'b1;
        cell_ctl.vis_wdata = 1'b1;
        st_nxt             = S_SCHK;
      end
      S_SCHK: begin
        if (grid_rdata == KIND_DEST) begin
          stk_ctl.we = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = {st_row, st_col, DIR_DOWN};
          depth_nxt  = DW'(1);
          found_nxt  = 1'b1;
          acc_nxt    = 1'b1;
          st_nxt     = S_DONE;
        end else begin
          cur_row_nxt = st_row;
          cur_col_nxt = st_col;
          cur_dir_nxt = DIR_DOWN;
          st_nxt      = S_PROBE;
        end
      end
      S_PROBE: begin
        cell_addr = {nb_row, nb_col};
        if (cur_dir_r == DIR_DONE) begin
          if (depth_r == '0) begin
            found_nxt = 1'b0;
            acc_nxt   = 1'b1;
            st_nxt    = S_DONE;
          end else begin
            depth_nxt = depth_r - DW'(1);
            if (depth_r == DW'(1)) begin
              cur_row_nxt = st_row;
              cur_col_nxt = st_col;
              cur_dir_nxt = sdir_r;
            end else begin
              stk_ctl.re = 1'b1;
              stk_raddr  = SAW'(depth_r - DW'(2));
              st_nxt     = S_POPW;
            end
          end
        end else begin
          cur_dir_nxt = cur_dir_r + DIR_W'(1);
          if (nb_ok) begin
            nbr_row_nxt = nb_row;
            nbr_col_nxt = nb_col;
            st_nxt      = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        st_nxt = S_PROBE;
        if (!vis_rdata && (grid_rdata != KIND_BLOCKED)) begin
          cell_ctl.vis_we    = 1'b1;
          cell_ctl.vis_wdata = 1'b1;
          if (depth_r == '0) begin
            sdir_nxt = cur_dir_r;
          end else begin
            stk_ctl.we = 1'b1;
            stk_waddr  = SAW'(depth_r - DW'(1));
            stk_wdata  = {cur_row_r, cur_col_r, cur_dir_r};
          end
          depth_nxt = depth_r + DW'(1);
          if (grid_rdata == KIND_DEST) begin
            st_nxt = S_FWR;
          end else begin
            cur_row_nxt = nbr_row_r;
            cur_col_nxt = nbr_col_r;
            cur_dir_nxt = DIR_DOWN;
          end
        end
      end
      S_POPW: begin
        {cur_row_nxt, cur_col_nxt, cur_dir_nxt} = stk_rdata;
        st_nxt = S_PROBE;
      end
      S_FWR: begin
        stk_ctl.we = 1'b1;
        stk_waddr  = SAW'(depth_r - DW'(1));
        stk_wdata  = {nbr_row_r, nbr_col_r, DIR_DOWN};
        found_nxt  = 1'b1;
        acc_nxt    = 1'b1;
        st_nxt     = S_DONE;
      end
      S_RDW: begin
        srow_nxt = COORD_W'(stk_rdata[EW_TOP:EW_TOP-LW+1]);
        scol_nxt = COORD_W'(stk_rdata[DIR_W+LW-1:DIR_W]);
        acc_nxt  = 1'b1;
        st_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_found_nxt = found_r;
          out_len_nxt   = LEN_W'(depth_r);
          out_row_nxt   = srow_r;
          out_col_nxt   = scol_r;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      depth_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      depth_r     <= depth_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    kind_r    <= kind_nxt;
    step_r    <= step_nxt;
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    cur_dir_r <= cur_dir_nxt;
    sdir_r    <= sdir_nxt;
    nbr_row_r <= nbr_row_nxt;
    nbr_col_r <= nbr_col_nxt;
    acc_r     <= acc_nxt;
    srow_r    <= srow_nxt;
    scol_r    <= scol_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    out_acc_r   <= out_acc_nxt;
    out_found_r <= out_found_nxt;
    out_len_r   <= out_len_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign in_ready        = (st_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_path_found  = out_found_r;
  assign out_path_length = out_len_r;
  assign out_step_row    = out_row_r;
  assign out_step_col    = out_col_r;

endmodule

[hw/rtl/gdfs_checker.sv]
// Port-level checks for the grid path finder, bound to the top level.
// Depends on gdfs_pkg for field widths.
module gdfs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_accepted,
  input logic                          out_path_found,
  input logic [gdfs_pkg::LEN_W-1:0]    out_path_length,
  input logic [gdfs_pkg::COORD_W-1:0]  out_step_row,
  input logic [gdfs_pkg::COORD_W-1:0]  out_step_col
);
  import gdfs_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_path_length) &&
    $stable(out_accepted))
    else $error("result beat changed while stalled");

  // No path means an empty stack
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_path_found |-> out_path_length == '0)
    else $error("path length without a path");

  // A found path holds at least the destination
  a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_found |-> out_path_length != '0)
    else $error("found path of zero length");

  // Rejected commands report no step
  a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_step_row == '0 && out_step_col == '0)
    else $error("step coordinates on a rejected command");

  // One command at a time: drop ready after a beat is taken
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

endmodule

bind grid_dfs_path_finder gdfs_checker u_gdfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_accepted    (out_accepted),
  .out_path_found  (out_path_found),
  .out_path_length (out_path_length),
  .out_step_row    (out_step_row),
  .out_step_col    (out_step_col)
);
